// ===== rtl/intel_hex_record_encoder_core_assert.svh =====
// assertion macros shared by the intel hex encoder rtl
`ifndef INTEL_HEX_RECORD_ENCODER_CORE_ASSERT_SVH
`define INTEL_HEX_RECORD_ENCODER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// checked only while out of reset
`define IHX_ASSERT_RST(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every clock edge
`define IHX_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IHX_ASSERT_RST(name, clk, rst_n, prop, msg)
`define IHX_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

// ===== rtl/ihx_pkg.sv =====
// types, constants and character helpers of the intel hex encoder
package ihx_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_RECORD_LENGTH = 2'd0;
    localparam logic [1:0] CFG_LOAD_ADDRESS  = 2'd1;
    localparam logic [1:0] CFG_TOTAL_LENGTH  = 2'd2;

    localparam logic [7:0]  RECORD_LENGTH_RESET = 8'd16;
    localparam logic [15:0] LOAD_ADDRESS_RESET  = 16'd0;
    localparam logic [16:0] TOTAL_LENGTH_RESET  = 17'd256;

    // command queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // character steps of one command
    localparam logic [4:0] STEP_COLON    = 5'd0;
    localparam logic [4:0] STEP_COUNT_HI = 5'd1;
    localparam logic [4:0] STEP_COUNT_LO = 5'd2;
    localparam logic [4:0] STEP_ADDR_3   = 5'd3;
    localparam logic [4:0] STEP_ADDR_2   = 5'd4;
    localparam logic [4:0] STEP_ADDR_1   = 5'd5;
    localparam logic [4:0] STEP_ADDR_0   = 5'd6;
    localparam logic [4:0] STEP_TYPE_HI  = 5'd7;
    localparam logic [4:0] STEP_TYPE_LO  = 5'd8;
    localparam logic [4:0] STEP_DATA_HI  = 5'd9;
    localparam logic [4:0] STEP_DATA_LO  = 5'd10;
    localparam logic [4:0] STEP_CSUM_HI  = 5'd11;
    localparam logic [4:0] STEP_CSUM_LO  = 5'd12;
    localparam logic [4:0] STEP_NEWLINE  = 5'd13;
    localparam logic [4:0] STEP_EOF      = 5'd14;
    localparam logic [4:0] STEP_EOF_END  = 5'd25;

    localparam logic [6:0] CHAR_COLON   = 7'h3A;
    localparam logic [6:0] CHAR_ZERO    = 7'h30;
    localparam logic [6:0] CHAR_NEWLINE = 7'h0A;

    // one accepted byte, classified for the character sequencer
    typedef struct packed {
        logic        hdr;
        logic [7:0]  count;
        logic [15:0] addr;
        logic [7:0]  data;
        logic        close;
        logic [7:0]  csum;
        logic        eof;
    } cmd_t;

    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        logic [6:0] c;
        if (nib < 4'd10)
            c = 7'h30 + {3'd0, nib};
        else
            c = 7'h37 + {3'd0, nib};
        return c;
    endfunction

    // end-of-file record text
    function automatic logic [6:0] eof_char(input logic [3:0] idx);
        logic [6:0] c;
        case (idx)
            4'd0:    c = CHAR_COLON;
            4'd8:    c = 7'h31;
            4'd9:    c = 7'h46;
            4'd10:   c = 7'h46;
            4'd11:   c = CHAR_NEWLINE;
            default: c = CHAR_ZERO;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/ihx_front.sv =====
// front stage: configuration registers, record bookkeeping and command build
module ihx_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic [1:0]        cfg_index,
    input  logic [16:0]       cfg_data,
    input  logic              accept,
    input  logic [7:0]        data_byte,
    output ihx_pkg::cmd_t     cmd
);
    import ihx_pkg::*;

    logic [7:0]  record_length_reg;
    logic [15:0] load_address_reg;
    logic [16:0] total_length_reg;

    logic [16:0] rem_reg;
    logic [15:0] addr_reg;
    logic [7:0]  pos_reg;
    logic [7:0]  sum_reg;
    logic [7:0]  cnt_reg;

    logic        start;
    logic [16:0] tl_eff;
    logic [16:0] rem_eff;
    logic [15:0] addr_eff;
    logic [7:0]  rl_eff;
    logic [7:0]  new_count;
    logic        hdr;
    logic [7:0]  pos_eff;
    logic [7:0]  sum_eff;
    logic [7:0]  cnt_eff;
    logic [7:0]  sum_base;
    logic [7:0]  sum_new;
    logic [8:0]  pos_inc;
    logic        eof;
    logic        close;

    always_comb
    begin
        start    = (rem_reg == 17'd0);
        tl_eff   = (total_length_reg == 17'd0) ? 17'd1 : total_length_reg;
        rem_eff  = start ? tl_eff : rem_reg;
        addr_eff = start ? load_address_reg : addr_reg;
        pos_eff  = start ? 8'd0 : pos_reg;
        sum_eff  = start ? 8'd0 : sum_reg;
        rl_eff   = (record_length_reg == 8'd0) ? 8'd1 : record_length_reg;
        new_count = (rem_eff < {9'd0, rl_eff}) ? rem_eff[7:0] : rl_eff;
        hdr      = (pos_eff == 8'd0);
        cnt_eff  = hdr ? new_count : cnt_reg;
        sum_base = hdr ? (new_count + addr_eff[15:8] + addr_eff[7:0]) : sum_eff;
        sum_new  = sum_base + data_byte;
        pos_inc  = {1'b0, pos_eff} + 9'd1;
        eof      = (rem_eff == 17'd1);
        close    = (pos_inc >= {1'b0, cnt_eff}) || eof;

        cmd.hdr   = hdr;
        cmd.count = new_count;
        cmd.addr  = addr_eff;
        cmd.data  = data_byte;
        cmd.close = close;
        cmd.csum  = ~sum_new + 8'd1;
        cmd.eof   = eof;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            record_length_reg <= RECORD_LENGTH_RESET;
            load_address_reg  <= LOAD_ADDRESS_RESET;
            total_length_reg  <= TOTAL_LENGTH_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_RECORD_LENGTH: record_length_reg <= cfg_data[7:0];
                CFG_LOAD_ADDRESS:  load_address_reg  <= cfg_data[15:0];
                CFG_TOTAL_LENGTH:  total_length_reg  <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= 17'd0;
            addr_reg <= 16'd0;
            pos_reg  <= 8'd0;
            sum_reg  <= 8'd0;
            cnt_reg  <= 8'd0;
        end
        else if (accept)
        begin
            rem_reg  <= rem_eff - 17'd1;
            addr_reg <= addr_eff + 16'd1;
            pos_reg  <= close ? 8'd0 : pos_inc[7:0];
            sum_reg  <= close ? 8'd0 : sum_new;
            cnt_reg  <= cnt_eff;
        end
    end

endmodule

// ===== rtl/ihx_fifo.sv =====
// short command queue between front and back stages
`include "intel_hex_record_encoder_core_assert.svh"

module ihx_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ihx_pkg::cmd_t  push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output ihx_pkg::cmd_t  head_cmd
);
    import ihx_pkg::*;

    localparam logic [QUEUE_AW:0] DEPTH = (QUEUE_AW + 1)'(QUEUE_DEPTH);

    cmd_t                mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;

    assign full       = (count_reg == DEPTH);
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    `IHX_ASSERT_ALWAYS(a_count_bound, clk, !rst_n || (count_reg <= DEPTH), "queue overflow")
    `IHX_ASSERT_RST(a_no_pop_empty, clk, rst_n, pop |-> head_valid, "pop from empty queue")
    `IHX_ASSERT_RST(a_no_push_full, clk, rst_n, push |-> !full, "push into full queue")

endmodule

// ===== rtl/ihx_back.sv =====
// back stage: character sequencer with output register
`include "intel_hex_record_encoder_core_assert.svh"

module ihx_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  ihx_pkg::cmd_t  cmd,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [6:0]     out_char,
    output logic           is_last
);
    import ihx_pkg::*;

    logic       busy_reg;
    logic       busy_next;
    logic [4:0] step_reg;
    logic [4:0] step_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [6:0] out_char_reg;
    logic       is_last_reg;

    logic [4:0] cur_step;
    logic [4:0] eof_idx;
    logic [4:0] seq_step;
    logic       char_last;
    logic [6:0] char_val;
    logic       load;

    always_comb
    begin
        cur_step = busy_reg ? step_reg : (cmd.hdr ? STEP_COLON : STEP_DATA_HI);
        eof_idx  = cur_step - STEP_EOF;

        char_last = 1'b0;
        seq_step  = cur_step + 5'd1;
        case (cur_step)
            STEP_DATA_LO:
            begin
                if (cmd.close)
                    seq_step = STEP_CSUM_HI;
                else if (cmd.eof)
                    seq_step = STEP_EOF;
                else
                    char_last = 1'b1;
            end
            STEP_NEWLINE:
            begin
                if (cmd.eof)
                    seq_step = STEP_EOF;
                else
                    char_last = 1'b1;
            end
            STEP_EOF_END: char_last = 1'b1;
            default:      ;
        endcase

        case (cur_step) inside
            STEP_COLON:                char_val = CHAR_COLON;
            STEP_COUNT_HI:             char_val = hex_char(cmd.count[7:4]);
            STEP_COUNT_LO:             char_val = hex_char(cmd.count[3:0]);
            STEP_ADDR_3:               char_val = hex_char(cmd.addr[15:12]);
            STEP_ADDR_2:               char_val = hex_char(cmd.addr[11:8]);
            STEP_ADDR_1:               char_val = hex_char(cmd.addr[7:4]);
            STEP_ADDR_0:               char_val = hex_char(cmd.addr[3:0]);
            STEP_TYPE_HI, STEP_TYPE_LO: char_val = CHAR_ZERO;
            STEP_DATA_HI:              char_val = hex_char(cmd.data[7:4]);
            STEP_DATA_LO:              char_val = hex_char(cmd.data[3:0]);
            STEP_CSUM_HI:              char_val = hex_char(cmd.csum[7:4]);
            STEP_CSUM_LO:              char_val = hex_char(cmd.csum[3:0]);
            STEP_NEWLINE:              char_val = CHAR_NEWLINE;
            [STEP_EOF:STEP_EOF_END]:   char_val = eof_char(eof_idx[3:0]);
            default:                   char_val = CHAR_ZERO;
        endcase

        // output register takes a character when empty or being drained
        load = cmd_valid && (!out_valid_reg || out_ready);
        pop  = load && char_last;

        busy_next      = busy_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (load)
        begin
            out_valid_next = 1'b1;
            busy_next      = !char_last;
            step_next      = seq_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= STEP_COLON;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_char_reg <= char_val;
            is_last_reg  <= char_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign is_last   = is_last_reg;

    `IHX_ASSERT_RST(a_busy_has_cmd, clk, rst_n, busy_reg |-> cmd_valid, "sequencer busy without command")
    `IHX_ASSERT_RST(a_step_range, clk, rst_n, busy_reg |-> (step_reg <= STEP_EOF_END), "step out of range")
    `IHX_ASSERT_RST(a_pop_marks_last, clk, rst_n, pop |=> (out_valid && is_last), "pop without last char")

endmodule

// ===== rtl/intel_hex_record_encoder_core.sv =====
// top level of the intel hex (i8hex) record encoder
//
// usage:
//   in channel  (in_valid/in_ready, data_byte): one raw data byte per transfer
//   out channel (out_valid/out_ready, out_char, is_last): one ascii character
//     per transfer, is_last high on the final character caused by one byte
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 record
//     length, 1 load address, 2 total length; always ready, write while idle
// a byte's first character reaches out through the queue write, then the
//   sequencer filling the output register
// the sequencer makes one character per cycle while a command waits and the
//   receiver takes it; a byte gives 2 characters, a record header 9 more, a
//   close 3, end-of-file 12: 2.75 characters per byte with 16-byte records
// the front takes bytes into a four-entry command queue while the back drains
//   it, so input keeps flowing while output is stalled until the queue fills
// reset: config returns to 16 / 0 / 256, no conversion is open, queue and
//   output register are empty
// receiver stall: the output register holds its character and the sequencer
//   waits; in_ready drops only once the queue is full
module intel_hex_record_encoder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [6:0]  out_char,
    output logic        is_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data
);
    import ihx_pkg::*;

    cmd_t front_cmd;
    cmd_t head_cmd;
    logic queue_full;
    logic head_valid;
    logic in_xfer;
    logic pop;

    // byte transfer whenever the queue has room
    assign in_ready  = !queue_full;
    assign in_xfer   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // classify the byte: header needed, close needed, end of conversion
    ihx_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (in_xfer),
        .data_byte (data_byte),
        .cmd       (front_cmd)
    );

    ihx_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_xfer),
        .push_cmd   (front_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // expand one command into its characters
    ihx_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (head_valid),
        .cmd       (head_cmd),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .is_last   (is_last)
    );

endmodule
